// ----- sv/fpcf_pkg.sv -----
`default_nettype none
package fpcf_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0] MARK          = 8'hF5;
    localparam logic [7:0] TIMEOUT_RESET = 8'd200;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_WRONG_CMD = 3'd2;
    localparam logic [2:0] ST_BAD_CHK   = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;

    localparam logic [7:0] CMD_ADD_ONE   = 8'h01;
    localparam logic [7:0] CMD_ADD_TWO   = 8'h02;
    localparam logic [7:0] CMD_ADD_THREE = 8'h03;
    localparam logic [7:0] CMD_DEL_USER  = 8'h04;
    localparam logic [7:0] CMD_DEL_ALL   = 8'h05;
    localparam logic [7:0] CMD_USER_CNT  = 8'h09;
    localparam logic [7:0] CMD_MATCH_ONE = 8'h0B;
    localparam logic [7:0] CMD_IDENTIFY  = 8'h0C;

    localparam logic [7:0] ACK_GOOD    = 8'h00;
    localparam logic [7:0] PRIV_ONE    = 8'h01;
    localparam logic [7:0] PRIV_TWO    = 8'h02;
    localparam logic [7:0] PRIV_THREE  = 8'h03;

    // reply byte positions
    localparam logic [IDX_W-1:0] POS_START = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_CMD   = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_ID    = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_ACK   = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_CHK   = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_END   = IDX_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] cmd_code;
        logic [7:0] param_one;
        logic [7:0] param_two;
        logic [7:0] param_three;
        logic [7:0] param_four;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] cmd_code;
        logic [7:0] param_one;
        logic [7:0] param_two;
        logic [7:0] param_three;
        logic [7:0] param_four;
        logic [7:0] chk;
        logic       success;
        logic [2:0] status;
        logic [7:0] user_id;
        logic [7:0] ack_code;
    } t_res;

    function automatic logic ack_accepts(input logic [7:0] cmd, input logic [7:0] ack);
        logic acc;
        case (cmd)
            CMD_ADD_ONE, CMD_ADD_TWO, CMD_ADD_THREE, CMD_DEL_USER,
            CMD_DEL_ALL, CMD_USER_CNT, CMD_MATCH_ONE: begin
                acc = (ack == ACK_GOOD);
            end
            CMD_IDENTIFY: begin
                acc = (ack == PRIV_ONE) || (ack == PRIV_TWO) || (ack == PRIV_THREE);
            end
            default: begin
                acc = 1'b0;
            end
        endcase
        return acc;
    endfunction

endpackage
`default_nettype wire

// ----- sv/fpcf_in_stage.sv -----
`default_nettype none
module fpcf_in_stage
    import fpcf_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  wire   i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

    a_held_until_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |=> (r_valid && $stable(r_item)))
        else $error("held item lost before it was taken");

endmodule
`default_nettype wire

// ----- sv/fpcf_core.sv -----
`default_nettype none
module fpcf_core
    import fpcf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_adv,
    input  t_item      i_item,
    output logic       o_has_res,
    output t_res       o_res
);

    logic [7:0]       r_timeout,  n_timeout;
    logic [7:0]       r_expected, n_expected;
    logic             r_waiting,  n_waiting;
    logic [IDX_W-1:0] r_rx_count, n_rx_count;
    logic [7:0]       r_rx_xor,   n_rx_xor;
    logic             r_start_ok, n_start_ok;
    logic             r_cmd_ok,   n_cmd_ok;
    logic [7:0]       r_id_byte,  n_id_byte;
    logic [7:0]       r_ack_byte, n_ack_byte;
    logic [7:0]       r_ticks,    n_ticks;

    logic [2:0] judged;

    always_comb begin
        if (!r_start_ok) begin
            judged = ST_BAD_START;
        end else if (!r_cmd_ok) begin
            judged = ST_WRONG_CMD;
        end else if (r_rx_xor != 8'd0) begin
            judged = ST_BAD_CHK;
        end else if (ack_accepts(r_expected, r_ack_byte)) begin
            judged = ST_OK;
        end else begin
            judged = ST_REJECTED;
        end
    end

    always_comb begin
        n_timeout  = i_cfg_we ? i_cfg_data : r_timeout;
        n_expected = r_expected;
        n_waiting  = r_waiting;
        n_rx_count = r_rx_count;
        n_rx_xor   = r_rx_xor;
        n_start_ok = r_start_ok;
        n_cmd_ok   = r_cmd_ok;
        n_id_byte  = r_id_byte;
        n_ack_byte = r_ack_byte;
        n_ticks    = r_ticks;
        o_has_res  = 1'b0;
        o_res      = '0;
        if (i_adv) begin
            case (i_item.opcode)
                OP_SEND: begin
                    o_has_res         = 1'b1;
                    o_res.kind        = KIND_TX;
                    o_res.cmd_code    = i_item.cmd_code;
                    o_res.param_one   = i_item.param_one;
                    o_res.param_two   = i_item.param_two;
                    o_res.param_three = i_item.param_three;
                    o_res.param_four  = i_item.param_four;
                    o_res.chk         = i_item.cmd_code ^ i_item.param_one ^ i_item.param_two
                                        ^ i_item.param_three ^ i_item.param_four;
                    n_expected = i_item.cmd_code;
                    n_waiting  = 1'b1;
                    n_rx_count = '0;
                    n_rx_xor   = 8'd0;
                    n_start_ok = 1'b0;
                    n_cmd_ok   = 1'b0;
                    n_ticks    = r_timeout;
                end
                OP_RX: begin
                    if (r_waiting) begin
                        if (r_rx_count >= POS_CMD && r_rx_count <= POS_CHK) begin
                            n_rx_xor = r_rx_xor ^ i_item.rx_byte;
                        end
                        case (r_rx_count)
                            POS_START: n_start_ok = (i_item.rx_byte == MARK);
                            POS_CMD:   n_cmd_ok   = (i_item.rx_byte == r_expected);
                            POS_ID:    n_id_byte  = i_item.rx_byte;
                            POS_ACK:   n_ack_byte = i_item.rx_byte;
                            default: begin
                            end
                        endcase
                        if (r_rx_count == POS_END) begin
                            // last reply byte leaves the checked fields untouched
                            o_has_res      = 1'b1;
                            o_res.kind     = KIND_VERDICT;
                            o_res.status   = judged;
                            o_res.success  = (judged == ST_OK);
                            o_res.user_id  = r_id_byte;
                            o_res.ack_code = r_ack_byte;
                            n_waiting      = 1'b0;
                            n_rx_count     = '0;
                        end else begin
                            n_rx_count = r_rx_count + IDX_W'(1);
                        end
                    end
                end
                OP_TICK: begin
                    if (r_waiting) begin
                        if (r_ticks <= 8'd1) begin
                            o_has_res    = 1'b1;
                            o_res.kind   = KIND_VERDICT;
                            o_res.status = ST_TIMEOUT;
                            n_ticks      = 8'd0;
                            n_waiting    = 1'b0;
                            n_rx_count   = '0;
                        end else begin
                            n_ticks = r_ticks - 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_expected <= 8'd0;
            r_waiting  <= 1'b0;
            r_rx_count <= '0;
            r_rx_xor   <= 8'd0;
            r_start_ok <= 1'b0;
            r_cmd_ok   <= 1'b0;
            r_id_byte  <= 8'd0;
            r_ack_byte <= 8'd0;
            r_ticks    <= 8'd0;
        end else begin
            r_timeout  <= n_timeout;
            r_expected <= n_expected;
            r_waiting  <= n_waiting;
            r_rx_count <= n_rx_count;
            r_rx_xor   <= n_rx_xor;
            r_start_ok <= n_start_ok;
            r_cmd_ok   <= n_cmd_ok;
            r_id_byte  <= n_id_byte;
            r_ack_byte <= n_ack_byte;
            r_ticks    <= n_ticks;
        end
    end

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_waiting |-> (r_rx_count == '0))
        else $error("reply count not cleared outside a wait");

    a_send_arms_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.opcode == OP_SEND && !i_cfg_we)
        |=> (r_waiting && r_ticks == $past(r_timeout)))
        else $error("send did not arm the reply wait");

    a_verdict_ends_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_has_res && o_res.kind == KIND_VERDICT) |=> !r_waiting)
        else $error("verdict left the wait armed");

endmodule
`default_nettype wire

// ----- sv/fpcf_out_stage.sv -----
`default_nettype none
module fpcf_out_stage
    import fpcf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_load,
    input  t_res       i_res,
    output logic       o_free,
    output logic       o_valid,
    input  wire        i_stall,
    output logic       o_kind,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    output logic       o_success,
    output logic [2:0] o_status,
    output logic [7:0] o_user_id,
    output logic [7:0] o_ack_code
);

    logic             r_valid;
    t_res             r_res;
    logic [IDX_W-1:0] r_idx;
    logic             take;

    assign take   = r_valid && !i_stall;
    assign o_free = !r_valid || (take && o_last);

    always_comb begin
        o_tx_byte = 8'd0;
        if (r_res.kind == KIND_TX) begin
            case (r_idx)
                IDX_W'(0): o_tx_byte = MARK;
                IDX_W'(1): o_tx_byte = r_res.cmd_code;
                IDX_W'(2): o_tx_byte = r_res.param_one;
                IDX_W'(3): o_tx_byte = r_res.param_two;
                IDX_W'(4): o_tx_byte = r_res.param_three;
                IDX_W'(5): o_tx_byte = r_res.param_four;
                IDX_W'(6): o_tx_byte = r_res.chk;
                default:   o_tx_byte = MARK;
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_res.kind;
    assign o_last     = (r_res.kind == KIND_VERDICT) || (r_idx == POS_END);
    assign o_success  = r_res.success;
    assign o_status   = r_res.status;
    assign o_user_id  = r_res.user_id;
    assign o_ack_code = r_res.ack_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_free) begin
            r_valid <= i_load;
            r_idx   <= '0;
        end else if (take) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    a_verdict_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind == KIND_VERDICT) |-> (r_idx == '0))
        else $error("verdict item with a nonzero byte index");

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_last) |=> (r_valid && r_idx == $past(r_idx) + IDX_W'(1)))
        else $error("frame broken before its last byte");

endmodule
`default_nettype wire

// ----- sv/fingerprint_cmd_framer_and_reply_checker_core.sv -----
`default_nettype none
// Command framer and reply checker for a serial fingerprint module. Each input item is
// registered, then handled combinationally: a send item loads the output stage with an
// eight-byte frame (0xF5, command, four parameters, their XOR, 0xF5), a received byte
// updates the reply check and, on the eighth byte, yields one verdict item, and a tick
// counts down the reply timeout and yields a timeout verdict when it expires. An item
// leaves the input register only when the output stage is empty or handing over its
// last byte, and its result appears in the next cycle. With no output stall items pass
// one per cycle, except that a send holds the item after it until its frame has gone
// out; output stalls lengthen that wait. One further item is held in the input register
// meanwhile. The timeout register may be written only while idle.
module fingerprint_cmd_framer_and_reply_checker_core
    import fpcf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [1:0] i_opcode,
    input  wire  [7:0] i_cmd_code,
    input  wire  [7:0] i_param_one,
    input  wire  [7:0] i_param_two,
    input  wire  [7:0] i_param_three,
    input  wire  [7:0] i_param_four,
    input  wire  [7:0] i_rx_byte,
    output logic       o_valid,
    input  wire        i_stall,
    output logic       o_kind,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    output logic       o_success,
    output logic [2:0] o_status,
    output logic [7:0] o_user_id,
    output logic [7:0] o_ack_code
);

    t_item in_item;
    t_item held_item;
    logic  held_valid;
    logic  out_free;
    logic  adv;
    logic  has_res;
    t_res  res;

    assign in_item.opcode      = i_opcode;
    assign in_item.cmd_code    = i_cmd_code;
    assign in_item.param_one   = i_param_one;
    assign in_item.param_two   = i_param_two;
    assign in_item.param_three = i_param_three;
    assign in_item.param_four  = i_param_four;
    assign in_item.rx_byte     = i_rx_byte;

    assign adv = held_valid && out_free;

    fpcf_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_take  (adv),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    fpcf_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_adv      (adv),
        .i_item     (held_item),
        .o_has_res  (has_res),
        .o_res      (res)
    );

    fpcf_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (has_res),
        .i_res      (res),
        .o_free     (out_free),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_kind     (o_kind),
        .o_tx_byte  (o_tx_byte),
        .o_last     (o_last),
        .o_success  (o_success),
        .o_status   (o_status),
        .o_user_id  (o_user_id),
        .o_ack_code (o_ack_code)
    );

endmodule
`default_nettype wire
